>>> hdl/mcfd_pkg.sv
// Shared constants and types for the motor/compass frame decoder.
package mcfd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned PORT_W    = 3;
   localparam int unsigned EVENT_W   = 2;
   localparam int unsigned HEADING_W = 19;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned RSP_W     = 24;

   // source ports
   localparam logic [PORT_W-1:0] PORT_NONE    = 3'd0;
   localparam logic [PORT_W-1:0] PORT_MOTOR   = 3'd2;
   localparam logic [PORT_W-1:0] PORT_COMPASS = 3'd4;
   localparam logic [PORT_W-1:0] PORT_LAST    = 3'd4;

   // register indexes
   localparam logic CSR_LEFT_ID  = 1'b0;
   localparam logic CSR_RIGHT_ID = 1'b1;

   localparam logic [BYTE_W-1:0] LEFT_ID_RESET  = 8'h0A;
   localparam logic [BYTE_W-1:0] RIGHT_ID_RESET = 8'h14;

   // motor frame
   localparam logic [BYTE_W-1:0]  MOTOR_START  = 8'hAC;
   localparam logic [COUNT_W-1:0] MOTOR_LAST   = 4'd10;
   localparam logic [BYTE_W-1:0]  ARRIVE_MARK  = 8'hAA;
   localparam logic [BYTE_W-1:0]  ALARM_MARK   = 8'hEE;

   // compass frame
   localparam logic [BYTE_W-1:0]  COMPASS_START = 8'h68;
   localparam logic [COUNT_W-1:0] COMPASS_LAST  = 4'd13;
   localparam logic [3:0]         SIGN_NEG      = 4'h1;

   typedef enum logic [EVENT_W-1:0] {
      EVENT_NONE    = 2'd0,
      EVENT_ARRIVED = 2'd1,
      EVENT_ALARM   = 2'd2
   } motor_event_type;

   typedef struct packed {
      motor_event_type event_code;
      logic            side;
   } motor_result_type;

   typedef struct packed {
      logic                        valid;
      logic signed [HEADING_W-1:0] hundredths;
   } heading_result_type;

endpackage

>>> hdl/mcfd_motor.sv
// Motor link frame tracker: keeps the bytes it needs and reports on the last byte.
module mcfd_motor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [mcfd_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [mcfd_pkg::BYTE_W-1:0]    left_id,
   input  logic [mcfd_pkg::BYTE_W-1:0]    right_id,
   output mcfd_pkg::motor_result_type     result
);
   import mcfd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  node_ff, mark_a_ff, mark_b_ff, status_ff;
   logic [COUNT_W-1:0] slot;
   logic               is_start, stores, done;
   logic               is_left, is_right;

   assign is_start = (rx_byte == MOTOR_START);
   assign stores   = !is_start && (count_ff < MOTOR_LAST);
   assign slot     = count_ff + 4'd1;
   assign done     = step && stores && (slot == MOTOR_LAST);

   always_comb begin
      count_in = count_ff;
      if (step) begin
         if (is_start) begin
            count_in = '0;
         end else if (stores) begin
            count_in = slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // only frame bytes 1, 3, 4 and 5 matter for the report
   always_ff @(posedge clock) begin
      if (step && stores) begin
         case (slot)
            4'd1: node_ff   <= rx_byte;
            4'd3: mark_a_ff <= rx_byte;
            4'd4: mark_b_ff <= rx_byte;
            4'd5: status_ff <= rx_byte;
            default: ;
         endcase
      end
   end

   assign is_left  = (node_ff == left_id);
   assign is_right = !is_left && (node_ff == right_id);

   always_comb begin
      result.event_code = EVENT_NONE;
      result.side       = 1'b0;
      if (done && (is_left || is_right)) begin
         if (mark_a_ff == ARRIVE_MARK && mark_b_ff == ARRIVE_MARK && status_ff[0]) begin
            result.event_code = EVENT_ARRIVED;
         end else if (mark_a_ff == ALARM_MARK && mark_b_ff == ALARM_MARK
                      && status_ff != '0) begin
            result.event_code = EVENT_ALARM;
         end
         if (result.event_code != EVENT_NONE) begin
            result.side = is_right;
         end
      end
   end

endmodule

>>> hdl/mcfd_compass.sv
// Compass frame tracker and packed-BCD heading decode.
module mcfd_compass (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [mcfd_pkg::BYTE_W-1:0]    rx_byte,
   output mcfd_pkg::heading_result_type   result
);
   import mcfd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  b0_ff, b1_ff, b2_ff;
   logic [COUNT_W-1:0] slot;
   logic               is_start, stores, done;
   logic [17:0]        mag;
   logic [HEADING_W-1:0] value;

   assign is_start = (rx_byte == COMPASS_START);
   assign stores   = !is_start && (count_ff < COMPASS_LAST);
   assign slot     = count_ff + 4'd1;
   assign done     = step && stores && (slot == COMPASS_LAST);

   always_comb begin
      count_in = count_ff;
      if (step) begin
         if (is_start) begin
            count_in = '0;
         end else if (stores) begin
            count_in = slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && stores) begin
         case (slot)
            4'd10: b0_ff <= rx_byte;
            4'd11: b1_ff <= rx_byte;
            4'd12: b2_ff <= rx_byte;
            default: ;
         endcase
      end
   end

   // nibbles are weighted as digits with no range check; max 166665
   always_comb begin
      mag = 18'(b0_ff[3:0]) * 18'd10000 + 18'(b1_ff[7:4]) * 18'd1000
          + 18'(b1_ff[3:0]) * 18'd100 + 18'(b2_ff[7:4]) * 18'd10 + 18'(b2_ff[3:0]);
      value = {1'b0, mag};
      if (b0_ff[7:4] == SIGN_NEG) begin
         value = -value;
      end
      result.valid      = done;
      result.hundredths = done ? value : '0;
   end

endmodule

>>> hdl/motor_compass_frame_decoder_unit.sv
// Top level of the motor/compass frame decoder.
// Takes one tagged received byte per clock when not stalled and returns exactly
// one result per byte via the input register, then the result register. The
// only loop is the per-port frame counter and byte store, which updates in the
// same cycle the byte leaves the input register. A byte is taken while the
// result register is full as long as the input register is free. Register
// writes are accepted every cycle.
module motor_compass_frame_decoder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [7:0] rx_byte
   input  logic [2:0]                   req_tuser,  // [2:0] port_number
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] motor_event, [2] motor_side, [3] heading_valid,
   // [22:4] heading_hundredths, [23] port_error
   output logic [mcfd_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [7:0]                   csr_data
);
   import mcfd_pkg::*;

   logic [BYTE_W-1:0]   left_node_ff, right_node_ff;
   logic                s1_valid_ff;
   logic [PORT_W-1:0]   s1_port_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                advance, step, port_err;
   motor_result_type    motor_res;
   heading_result_type  heading_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_node_ff  <= LEFT_ID_RESET;
         right_node_ff <= RIGHT_ID_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEFT_ID:  left_node_ff  <= csr_data;
            CSR_RIGHT_ID: right_node_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign step       = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_port_ff <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
   end

   mcfd_motor u_motor (
      .clock    (clock),
      .reset    (reset),
      .step     (step && s1_port_ff == PORT_MOTOR),
      .rx_byte  (s1_byte_ff),
      .left_id  (left_node_ff),
      .right_id (right_node_ff),
      .result   (motor_res)
   );

   mcfd_compass u_compass (
      .clock   (clock),
      .reset   (reset),
      .step    (step && s1_port_ff == PORT_COMPASS),
      .rx_byte (s1_byte_ff),
      .result  (heading_res)
   );

   assign port_err = (s1_port_ff == PORT_NONE) || (s1_port_ff > PORT_LAST);

   // sub-blocks report zeros unless their own port just completed a frame
   assign rsp_data_in = {port_err, heading_res.hundredths, heading_res.valid,
                         motor_res.side, motor_res.event_code};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/mcfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
module mcfd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [mcfd_pkg::RSP_W-1:0]  rsp_tdata
);
   import mcfd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_port_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[22:0] == '0)
      else $error("bad-port result carries data");

   a_heading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[22:4] == '0)
      else $error("heading without heading_valid");

   a_motor_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3
                     && (rsp_tdata[1:0] != EVENT_NONE || !rsp_tdata[2]))
      else $error("bad motor event or side");

endmodule

bind motor_compass_frame_decoder_unit mcfd_checker u_mcfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/mcfd_decode_checker.sv
// Checker for the motor/compass frame decoder: predicts every result and compares.
`timescale 1ns / 1ps

module mcfd_decode_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic [2:0]                  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [mcfd_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_data,
   output int                          error_count,
   output int                          pending_count
);
   import mcfd_pkg::*;

   // same bit order as rsp_tdata
   typedef struct packed {
      logic                        port_error;
      logic signed [HEADING_W-1:0] heading;
      logic                        heading_valid;
      logic                        side;
      motor_event_type             event_code;
   } decoded_byte_type;

   decoded_byte_type expected_results[$];

   logic [BYTE_W-1:0]  left_id;
   logic [BYTE_W-1:0]  right_id;
   logic [COUNT_W-1:0] motor_pos;
   logic [COUNT_W-1:0] compass_pos;
   logic [BYTE_W-1:0]  motor_bytes [0:10];
   logic [BYTE_W-1:0]  compass_bytes [0:13];
   int                 mismatches;

   // packed BCD: sign nibble, then three integer and two decimal digits
   function automatic logic signed [HEADING_W-1:0] bcd_heading(input logic [7:0] b0,
                                                               input logic [7:0] b1,
                                                               input logic [7:0] b2);
      int mag;
      mag = int'(b0[3:0]) * 10000 + int'(b1[7:4]) * 1000 + int'(b1[3:0]) * 100
          + int'(b2[7:4]) * 10 + int'(b2[3:0]);
      if (b0[7:4] == SIGN_NEG) begin
         mag = -mag;
      end
      return mag[HEADING_W-1:0];
   endfunction

   function automatic decoded_byte_type decode_byte(input logic [PORT_W-1:0] port,
                                                    input logic [BYTE_W-1:0] b);
      decoded_byte_type r;
      logic             known;
      r     = '0;
      known = 1'b0;
      if (port == PORT_NONE || port > PORT_LAST) begin
         r.port_error = 1'b1;
      end else if (port == PORT_MOTOR) begin
         if (b == MOTOR_START) begin
            foreach (motor_bytes[i]) motor_bytes[i] = '0;
            motor_pos      = '0;
            motor_bytes[0] = b;
         end else if (motor_pos < MOTOR_LAST) begin
            motor_pos              = motor_pos + 1'b1;
            motor_bytes[motor_pos] = b;
            if (motor_pos == MOTOR_LAST) begin
               // equal ids resolve to the left drive
               if (motor_bytes[1] == left_id) begin
                  known = 1'b1;
               end else if (motor_bytes[1] == right_id) begin
                  known  = 1'b1;
                  r.side = 1'b1;
               end
               if (known) begin
                  if (motor_bytes[3] == ARRIVE_MARK && motor_bytes[4] == ARRIVE_MARK
                      && motor_bytes[5][0]) begin
                     r.event_code = EVENT_ARRIVED;
                  end else if (motor_bytes[3] == ALARM_MARK && motor_bytes[4] == ALARM_MARK
                               && motor_bytes[5] != '0) begin
                     r.event_code = EVENT_ALARM;
                  end
               end
               if (r.event_code == EVENT_NONE) begin
                  r.side = 1'b0;
               end
            end
         end
      end else if (port == PORT_COMPASS) begin
         if (b == COMPASS_START) begin
            foreach (compass_bytes[i]) compass_bytes[i] = '0;
            compass_pos      = '0;
            compass_bytes[0] = b;
         end else if (compass_pos < COMPASS_LAST) begin
            compass_pos                = compass_pos + 1'b1;
            compass_bytes[compass_pos] = b;
            if (compass_pos == COMPASS_LAST) begin
               r.heading_valid = 1'b1;
               r.heading = bcd_heading(compass_bytes[10], compass_bytes[11], compass_bytes[12]);
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         left_id     = LEFT_ID_RESET;
         right_id    = RIGHT_ID_RESET;
         motor_pos   = '0;
         compass_pos = '0;
         foreach (motor_bytes[i]) motor_bytes[i] = '0;
         foreach (compass_bytes[i]) compass_bytes[i] = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEFT_ID:  left_id  = csr_data;
               CSR_RIGHT_ID: right_id = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result %h", $realtime, rsp_tdata);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[1:0] !== want.event_code || rsp_tdata[2] !== want.side
                   || rsp_tdata[3] !== want.heading_valid
                   || rsp_tdata[22:4] !== want.heading
                   || rsp_tdata[23] !== want.port_error) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch: expected event %0d side %0d hvalid %0d",
                              $realtime, want.event_code, want.side, want.heading_valid,
                              " heading %0d perr %0d,", want.heading, want.port_error,
                              " got event %0d side %0d hvalid %0d",
                              rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[3],
                              " heading %0d perr %0d",
                              $signed(rsp_tdata[22:4]), rsp_tdata[23]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(decode_byte(req_tuser, req_tdata));
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

>>> sim/tb_motor_compass_frame_decoder_unit.sv
// Testbench top for the motor/compass frame decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_motor_compass_frame_decoder_unit;
   import mcfd_pkg::*;

   localparam logic [BYTE_W-1:0] MOTOR_DIRECTED [0:10] = '{
      MOTOR_START, LEFT_ID_RESET, 8'h00, ARRIVE_MARK, ARRIVE_MARK, 8'hFF,
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
   // negative extreme heading, every digit nibble above nine
   localparam logic [BYTE_W-1:0] COMPASS_DIRECTED [0:13] = '{
      COMPASS_START, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
      8'h00, 8'h1F, 8'hFF, 8'hFF, 8'h00};

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic [2:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic              csr_index  = CSR_LEFT_ID;
   logic [7:0]        csr_data   = '0;
   int                error_count;
   int                pending_count;

   int                idle_pct  = 0;
   int                stall_pct = 0;
   int                byte_count = 0;
   logic [BYTE_W-1:0] cur_left  = LEFT_ID_RESET;
   logic [BYTE_W-1:0] cur_right = RIGHT_ID_RESET;

   motor_compass_frame_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mcfd_decode_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic push_byte(input logic [PORT_W-1:0] port, input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= port;
      do @(posedge clock); while (!req_tready);
      byte_count++;
   endtask

   // waits until every request has its result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ids(input logic [BYTE_W-1:0] left_value,
                            input logic [BYTE_W-1:0] right_value);
      csr_valid <= 1'b1;
      csr_index <= CSR_LEFT_ID;
      csr_data  <= left_value;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_RIGHT_ID;
      csr_data  <= right_value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_left  = left_value;
      cur_right = right_value;
   endtask

   // payload byte; a stray start byte now and then restarts the frame
   function automatic logic [BYTE_W-1:0] payload_byte(input logic [BYTE_W-1:0] start);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      if (b == start && $urandom_range(9) != 0) begin
         b = b ^ 8'h01;
      end
      return b;
   endfunction

   // occasional byte from another port inside a frame
   task automatic interleave_noise(input logic [PORT_W-1:0] own_port);
      logic [PORT_W-1:0] port;
      if ($urandom_range(19) == 0) begin
         port = PORT_W'($urandom_range(7));
         while (port == own_port) port = PORT_W'($urandom_range(7));
         push_byte(port, BYTE_W'($urandom_range(255)));
      end
   endtask

   task automatic send_motor_frame();
      logic [BYTE_W-1:0] frame [0:10];
      int                sel;
      int                len;
      int                extra;
      frame[0] = MOTOR_START;
      for (int i = 1; i <= 10; i++) frame[i] = payload_byte(MOTOR_START);
      sel = $urandom_range(9);
      if (sel < 4) begin
         frame[1] = cur_left;
      end else if (sel < 8) begin
         frame[1] = cur_right;
      end
      sel = $urandom_range(9);
      if (sel < 4) begin
         frame[3] = ARRIVE_MARK;
         frame[4] = ARRIVE_MARK;
      end else if (sel < 8) begin
         frame[3] = ALARM_MARK;
         frame[4] = ALARM_MARK;
      end else if (sel == 8) begin
         frame[3] = ARRIVE_MARK;
         frame[4] = ALARM_MARK;
      end
      if ($urandom_range(3) == 0) begin
         frame[5] = '0;
      end
      len   = 11;
      extra = 0;
      sel   = $urandom_range(9);
      if (sel == 0) begin
         len = $urandom_range(10, 1);
      end else if (sel == 1) begin
         extra = $urandom_range(3, 1);
      end
      for (int i = 0; i < len; i++) begin
         interleave_noise(PORT_MOTOR);
         push_byte(PORT_MOTOR, frame[i]);
      end
      for (int i = 0; i < extra; i++) push_byte(PORT_MOTOR, payload_byte(MOTOR_START));
   endtask

   task automatic send_compass_frame();
      logic [BYTE_W-1:0] frame [0:13];
      int                sel;
      int                len;
      int                extra;
      frame[0] = COMPASS_START;
      for (int i = 1; i <= 13; i++) frame[i] = payload_byte(COMPASS_START);
      sel = $urandom_range(9);
      if (sel < 5) begin
         frame[10][7:4] = SIGN_NEG;
      end else if (sel < 8) begin
         frame[10][7:4] = 4'h0;
      end
      len   = 14;
      extra = 0;
      sel   = $urandom_range(9);
      if (sel == 0) begin
         len = $urandom_range(13, 1);
      end else if (sel == 1) begin
         extra = $urandom_range(3, 1);
      end
      for (int i = 0; i < len; i++) begin
         interleave_noise(PORT_COMPASS);
         push_byte(PORT_COMPASS, frame[i]);
      end
      for (int i = 0; i < extra; i++) push_byte(PORT_COMPASS, payload_byte(COMPASS_START));
   endtask

   initial begin
      int            goal;
      int            pick;
      logic [BYTE_W-1:0] shared_id;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: bad and unused ports, full arrival frame, byte past end, heading extreme
      push_byte(PORT_NONE, 8'h00);
      push_byte(PORT_LAST + 3'd1, 8'hFF);
      push_byte(3'b111, MOTOR_START);
      push_byte(PORT_MOTOR + 3'd1, COMPASS_START);
      for (int i = 0; i < 11; i++) push_byte(PORT_MOTOR, MOTOR_DIRECTED[i]);
      push_byte(PORT_MOTOR, 8'h55);
      for (int i = 0; i < 14; i++) push_byte(PORT_COMPASS, COMPASS_DIRECTED[i]);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_ids(8'h00, 8'hFF);
            1: write_ids(8'hFF, 8'h00);
            2: begin
               shared_id = BYTE_W'($urandom_range(255));
               write_ids(shared_id, shared_id);
            end
            3: write_ids(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
            default: write_ids(LEFT_ID_RESET, RIGHT_ID_RESET);
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         goal = byte_count + 220;
         while (byte_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               send_motor_frame();
            end else if (pick < 75) begin
               send_compass_frame();
            end else begin
               repeat ($urandom_range(4, 1)) begin
                  push_byte(PORT_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
               end
            end
         end
         // sender holds off until all results are back
         drain();
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
